>>> rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg: shared types and constants for the complex spectrum divider
// Fixed field widths, pipeline depths and the sideband record.
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

    localparam int Q_W       = 32;            // field width
    localparam int P_W       = 2 * Q_W;       // product / numerator width
    localparam int DIV_LAT   = Q_W + 2;       // divider: precheck, one stage per bit, output
    localparam int FRONT_LAT = 3;             // magnitude, product and sum stages
    localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + 1;

    typedef logic [Q_W-1:0] t_mag;
    typedef logic [P_W-1:0] t_wide;

    typedef struct packed {
        logic vld;
        logic cmd;
        logic zdiv;
        logic ar_pos;
        logic ar_neg;
    } t_side;

endpackage : csd_pkg

`default_nettype wire

>>> rtl/csd_div.sv
// ----------------------------------------------------------------------------
// csd_div: pipelined fixed-point quotient
// floor(num * 2^FRAC_BITS / den), one quotient bit per stage, signed and
// saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire csd_pkg::t_wide          i_num,
    input  wire csd_pkg::t_wide          i_den,
    input  wire                          i_neg,
    output logic signed [csd_pkg::Q_W-1:0] o_val,
    output logic                         o_sat
);

    localparam int QW = csd_pkg::Q_W;
    localparam int PW = csd_pkg::P_W;
    localparam int CW = PW + QW + 1;

    csd_pkg::t_wide r_rem [0:QW];
    csd_pkg::t_wide r_den [0:QW];
    csd_pkg::t_mag  r_low [0:QW];
    csd_pkg::t_mag  r_q   [0:QW];
    logic           r_neg [0:QW];
    logic           r_big [0:QW];

    logic [CW-1:0]  n_ncmp;
    logic [CW-1:0]  n_dcmp;

    always_comb begin
        n_ncmp = CW'(i_num) << FRAC_BITS;
        n_dcmp = CW'(i_den) << QW;
    end

    // quotient would not fit in 32 bits: flag now, the bit stages run on garbage
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num >> (QW - FRAC_BITS);
        r_low[0] <= QW'(i_num << FRAC_BITS);
        r_den[0] <= i_den;
        r_neg[0] <= i_neg;
        r_big[0] <= (n_ncmp >= n_dcmp);
        r_q[0]   <= '0;
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [PW:0] n_sh;
        logic [PW:0] n_diff;
        logic        n_ge;

        always_comb begin
            n_sh   = {r_rem[k-1], r_low[k-1][QW-1]};
            n_diff = n_sh - {1'b0, r_den[k-1]};
            n_ge   = (n_sh >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? n_diff[PW-1:0] : n_sh[PW-1:0];
            r_low[k] <= {r_low[k-1][QW-2:0], 1'b0};
            r_den[k] <= r_den[k-1];
            r_neg[k] <= r_neg[k-1];
            r_big[k] <= r_big[k-1];
            r_q[k]   <= {r_q[k-1][QW-2:0], n_ge};
        end
    end

    logic [QW:0]   n_limit;
    logic          n_sat;
    csd_pkg::t_mag n_mag;

    always_comb begin
        n_limit = r_neg[QW] ? {2'b01, {(QW-1){1'b0}}} : {2'b00, {(QW-1){1'b1}}};
        n_sat   = r_big[QW] || ({1'b0, r_q[QW]} > n_limit);
        n_mag   = n_sat ? n_limit[QW-1:0] : r_q[QW];
    end

    always_ff @(posedge i_clk) begin
        o_val <= r_neg[QW] ? -$signed(n_mag) : $signed(n_mag);
        o_sat <= n_sat;
    end

endmodule : csd_div

`default_nettype wire

>>> rtl/complex_spectrum_divider.sv
// ----------------------------------------------------------------------------
// complex_spectrum_divider: element-wise A/B over a spectrum, Q format
// Complex or lone-real quotient with saturation flag; conj_b set gives A*B/|B|^2.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while busy is low; a 32-stage restoring
// divider, one quotient bit per stage, sets the depth.
// Reset: synchronous, active low; clears valid bits and conj_b, holds busy high.
// Results cannot be stalled by the receiver.
`default_nettype none

module complex_spectrum_divider #(
    parameter int FRAC_BITS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire                             i_cmd,
    input  wire signed [csd_pkg::Q_W-1:0]   i_a_re,
    input  wire signed [csd_pkg::Q_W-1:0]   i_a_im,
    input  wire signed [csd_pkg::Q_W-1:0]   i_b_re,
    input  wire signed [csd_pkg::Q_W-1:0]   i_b_im,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire                             i_cfg_data,
    output logic                            o_done,
    output logic signed [csd_pkg::Q_W-1:0]  o_c_re,
    output logic signed [csd_pkg::Q_W-1:0]  o_c_im,
    output logic                            o_saturated
);

    localparam int QW = csd_pkg::Q_W;
    localparam int PW = csd_pkg::P_W;
    localparam int DL = csd_pkg::DIV_LAT;

    logic r_busy;
    logic r_conj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_conj <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_conj <= i_cfg_data;
            end
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    // ---- stage 1: signs and magnitudes
    logic        [QW:0] n_d;
    csd_pkg::t_mag      n_dmag;

    always_comb begin
        n_d    = {i_b_re[QW-1], i_b_re} + (QW+1)'(1);
        n_dmag = n_d[QW] ? QW'(-n_d) : n_d[QW-1:0];
    end

    csd_pkg::t_side r1_side;
    logic           r1_conj;
    csd_pkg::t_mag  r1_mar, r1_mai, r1_mbr, r1_mbi, r1_md;
    logic           r1_sar, r1_sai, r1_sbr, r1_sbi, r1_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
        end else begin
            r1_side.vld    <= start && !r_busy;
            r1_side.cmd    <= i_cmd;
            r1_side.zdiv   <= (n_d == '0);
            r1_side.ar_pos <= !i_a_re[QW-1] && (i_a_re != '0);
            r1_side.ar_neg <= i_a_re[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_conj <= r_conj;
        r1_mar  <= i_a_re[QW-1] ? QW'(-i_a_re) : i_a_re;
        r1_mai  <= i_a_im[QW-1] ? QW'(-i_a_im) : i_a_im;
        r1_mbr  <= i_b_re[QW-1] ? QW'(-i_b_re) : i_b_re;
        r1_mbi  <= i_b_im[QW-1] ? QW'(-i_b_im) : i_b_im;
        r1_md   <= n_dmag;
        r1_sar  <= i_a_re[QW-1];
        r1_sai  <= i_a_im[QW-1];
        r1_sbr  <= i_b_re[QW-1];
        r1_sbi  <= i_b_im[QW-1];
        r1_sd   <= n_d[QW];
    end

    // ---- stage 2: exact magnitude products
    csd_pkg::t_side r2_side;
    logic           r2_conj;
    csd_pkg::t_wide r2_rr, r2_ii, r2_ir, r2_ri, r2_bb, r2_qq;
    csd_pkg::t_mag  r2_mar, r2_md;
    logic           r2_n_rr, r2_n_ii, r2_n_ir, r2_n_ri, r2_neg_real;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side <= '0;
        end else begin
            r2_side <= r1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_conj     <= r1_conj;
        r2_rr       <= PW'(r1_mar) * PW'(r1_mbr);
        r2_ii       <= PW'(r1_mai) * PW'(r1_mbi);
        r2_ir       <= PW'(r1_mai) * PW'(r1_mbr);
        r2_ri       <= PW'(r1_mar) * PW'(r1_mbi);
        r2_bb       <= PW'(r1_mbr) * PW'(r1_mbr);
        r2_qq       <= PW'(r1_mbi) * PW'(r1_mbi);
        r2_n_rr     <= r1_sar ^ r1_sbr;
        r2_n_ii     <= r1_sai ^ r1_sbi;
        r2_n_ir     <= r1_sai ^ r1_sbr;
        r2_n_ri     <= r1_sar ^ r1_sbi;
        r2_neg_real <= r1_sar ^ r1_sd;
        r2_mar      <= r1_mar;
        r2_md       <= r1_md;
    end

    // ---- stage 3: signed sums and mode select
    logic           n_sre2, n_sim2, n_nre, n_nim;
    csd_pkg::t_wide n_mre, n_mim, n_den;

    always_comb begin
        n_sre2 = r2_n_ii ^ r2_conj;
        n_sim2 = r2_n_ri ^ !r2_conj;
        if (r2_n_rr == n_sre2) begin
            n_mre = r2_rr + r2_ii;
            n_nre = r2_n_rr;
        end else if (r2_rr >= r2_ii) begin
            n_mre = r2_rr - r2_ii;
            n_nre = r2_n_rr && (r2_rr != r2_ii);
        end else begin
            n_mre = r2_ii - r2_rr;
            n_nre = n_sre2;
        end
        if (r2_n_ir == n_sim2) begin
            n_mim = r2_ir + r2_ri;
            n_nim = r2_n_ir;
        end else if (r2_ir >= r2_ri) begin
            n_mim = r2_ir - r2_ri;
            n_nim = r2_n_ir && (r2_ir != r2_ri);
        end else begin
            n_mim = r2_ri - r2_ir;
            n_nim = n_sim2;
        end
        n_den = r2_bb + r2_qq + (PW'(1) << FRAC_BITS);
    end

    csd_pkg::t_side r3_side;
    csd_pkg::t_wide r3_num_re, r3_num_im, r3_den_re, r3_den_im;
    logic           r3_neg_re, r3_neg_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side <= '0;
        end else begin
            r3_side <= r2_side;
        end
    end

    // lone real: im lane divides zero by one so it stays clean
    always_ff @(posedge i_clk) begin
        if (r2_side.cmd) begin
            r3_num_re <= PW'(r2_mar);
            r3_den_re <= r2_side.zdiv ? PW'(1) : PW'(r2_md);
            r3_neg_re <= r2_neg_real;
            r3_num_im <= '0;
            r3_den_im <= PW'(1);
            r3_neg_im <= 1'b0;
        end else begin
            r3_num_re <= n_mre;
            r3_den_re <= n_den;
            r3_neg_re <= n_nre;
            r3_num_im <= n_mim;
            r3_den_im <= n_den;
            r3_neg_im <= n_nim;
        end
    end

    // ---- divider lanes
    logic signed [QW-1:0] w_q_re, w_q_im;
    logic                 w_sat_re, w_sat_im;

    csd_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .i_clk (i_clk),
        .i_num (r3_num_re),
        .i_den (r3_den_re),
        .i_neg (r3_neg_re),
        .o_val (w_q_re),
        .o_sat (w_sat_re)
    );

    csd_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .i_clk (i_clk),
        .i_num (r3_num_im),
        .i_den (r3_den_im),
        .i_neg (r3_neg_im),
        .o_val (w_q_im),
        .o_sat (w_sat_im)
    );

    // sideband rides alongside the divider stages
    csd_pkg::t_side r_sb [0:DL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) begin
                r_sb[k] <= '0;
            end
        end else begin
            r_sb[0] <= r3_side;
            for (int k = 1; k < DL; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---- output stage
    csd_pkg::t_side       w_last;
    logic                 r_done;
    logic signed [QW-1:0] r_c_re, r_c_im;
    logic                 r_sat;

    assign w_last = r_sb[DL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.cmd && w_last.zdiv) begin
            r_c_re <= w_last.ar_pos ? {1'b0, {(QW-1){1'b1}}}
                    : w_last.ar_neg ? {1'b1, {(QW-1){1'b0}}} : '0;
            r_c_im <= '0;
            r_sat  <= 1'b1;
        end else begin
            r_c_re <= w_q_re;
            r_c_im <= w_last.cmd ? '0 : w_q_im;
            r_sat  <= w_sat_re || w_sat_im;
        end
    end

    assign o_done      = r_done;
    assign o_c_re      = r_c_re;
    assign o_c_im      = r_c_im;
    assign o_saturated = r_sat;

endmodule : complex_spectrum_divider

`default_nettype wire

>>> rtl/csd_chk.sv
// ----------------------------------------------------------------------------
// csd_chk: port-level checks for the complex spectrum divider
// Fixed latency, lone-real imaginary part and zero-divisor flag.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_chk (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           start,
    input wire                           busy,
    input wire                           i_cmd,
    input wire signed [csd_pkg::Q_W-1:0] i_b_re,
    input wire                           o_done,
    input wire signed [csd_pkg::Q_W-1:0] o_c_im,
    input wire                           o_saturated
);

    localparam int LAT = csd_pkg::TOTAL_LAT;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("result strobe missing after accepted beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LAT !o_done)
        else $error("result strobe without accepted beat");

    a_real_im_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd) |-> ##LAT (o_c_im == '0))
        else $error("lone real beat gave nonzero imaginary part");

    a_zero_div_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd && (i_b_re == '1)) |-> ##LAT o_saturated)
        else $error("zero divisor did not raise saturation");

endmodule : csd_chk

bind complex_spectrum_divider csd_chk u_csd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .i_b_re      (i_b_re),
    .o_done      (o_done),
    .o_c_im      (o_c_im),
    .o_saturated (o_saturated)
);

`default_nettype wire
